### hw/rtl/stb_pkg.sv
// Shared codes for the timer bank: operation codes and result status codes.
// No dependencies; used by soft_timer_bank.
package stb_pkg;

    // Operation codes carried on func
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STOP  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_INIT  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EXPIRY  = 2'd2;

endpackage

### hw/rtl/soft_timer_bank.sv
// Top level of the soft timer bank: sequencer, run flags and output register.
// Depends on stb_pkg, stb_ram and stb_sub.
//
// A bank of NUM_TIMERS one-shot or periodic timers. Each input transfer
// carries one operation (start, stop, tick, init) and produces one or more
// result transfers; the final one of each operation has last set. Init,
// start and stop go from acceptance through the done state to the result.
// A tick walks every timer in ascending index order through one shared
// subtract and compare unit, one timer per cycle off the registered read
// of the time memories, except that the walk holds on a timer whose expiry
// event waits for the output register.
// Every expired timer yields one expiry event in index order, followed by a
// done result.
// The bank accepts a new operation only when the sequencer is idle, but a
// finished result may still sit in the output register at that point.
// Any operation other than init before the first init is rejected as
// invalid; start with a zero interval or an index past the bank is invalid.
// Time values are kept TIME_WIDTH bits wide; interval and elapsed are
// truncated or zero-extended to that width.
module soft_timer_bank #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [3:0]  timer_index,
    input  logic [31:0] interval,
    input  logic        periodic,
    input  logic [31:0] elapsed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  expired_index,
    output logic        last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [6:0] NUM_T7 = 7'(NUM_TIMERS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_EVAL  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    ready_reg, ready_next;
    logic [NUM_TIMERS-1:0]   running_reg, running_next;
    logic [NUM_TIMERS-1:0]   reload_reg, reload_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [TIME_WIDTH-1:0]   el_reg, el_next;
    logic [1:0]              pend_status_reg, pend_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              status_reg, status_next;
    logic [3:0]              exp_idx_reg, exp_idx_next;
    logic                    last_reg, last_next;

    logic                    in_accept;
    logic [TIME_WIDTH-1:0]   ivl_t;
    logic                    idx_ok;
    logic [IDX_W-1:0]        tindex;
    logic                    out_load;
    logic                    cur_run;
    logic                    at_last;
    logic                    need_emit;
    logic                    advance;

    logic                    emit;
    logic [1:0]              emit_status;
    logic [3:0]              emit_idx;
    logic                    emit_last;

    logic                    rem_we;
    logic [IDX_W-1:0]        rem_wr_addr;
    logic [TIME_WIDTH-1:0]   rem_wr_data;
    logic                    per_we;
    logic [IDX_W-1:0]        rd_addr;
    logic [TIME_WIDTH-1:0]   rem_rd;
    logic [TIME_WIDTH-1:0]   per_rd;
    logic [TIME_WIDTH-1:0]   unit_value;
    logic                    unit_expire;

    // Time memories: remaining time and period per timer
    stb_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_rem_ram (
        .clk     (clk),
        .wr_en   (rem_we),
        .wr_addr (rem_wr_addr),
        .wr_data (rem_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rem_rd)
    );

    stb_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_per_ram (
        .clk     (clk),
        .wr_en   (per_we),
        .wr_addr (tindex),
        .wr_data (ivl_t),
        .rd_addr (rd_addr),
        .rd_data (per_rd)
    );

    // One subtract and compare, shared by every timer of the walk
    stb_sub #(
        .WIDTH (TIME_WIDTH)
    ) u_sub (
        .remaining  (rem_rd),
        .elapsed    (el_reg),
        .period     (per_rd),
        .reload     (reload_reg[idx_reg]),
        .next_value (unit_value),
        .expire     (unit_expire)
    );

    // Take a new operation only while the sequencer idles
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);

    assign ivl_t  = TIME_WIDTH'(interval);
    assign idx_ok = ({3'b000, timer_index} < NUM_T7);
    assign tindex = IDX_W'(timer_index);

    // The output register can take a result when empty or being drained
    assign out_load = !out_valid_reg || !out_stall;

    assign cur_run   = running_reg[idx_reg];
    assign at_last   = (idx_reg == LAST_IDX);
    assign need_emit = cur_run && unit_expire;
    assign advance   = (state_reg == S_EVAL) && (!need_emit || out_load);

    always_comb
    begin
        state_next       = state_reg;
        ready_next       = ready_reg;
        running_next     = running_reg;
        reload_next      = reload_reg;
        idx_next         = idx_reg;
        el_next          = el_reg;
        pend_status_next = pend_status_reg;
        emit             = 1'b0;
        emit_status      = stb_pkg::ST_OK;
        emit_idx         = 4'd0;
        emit_last        = 1'b0;
        rem_we           = 1'b0;
        rem_wr_addr      = tindex;
        rem_wr_data      = ivl_t;
        per_we           = 1'b0;
        rd_addr          = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DONE;
                    if (func == stb_pkg::FUNC_INIT)
                    begin
                        // Clear the run flags; stale times are never used
                        ready_next       = 1'b1;
                        running_next     = '0;
                        reload_next      = '0;
                        pend_status_next = stb_pkg::ST_OK;
                    end
                    else if (!ready_reg)
                    begin
                        pend_status_next = stb_pkg::ST_INVALID;
                    end
                    else
                    begin
                        case (func)
                            stb_pkg::FUNC_START:
                            begin
                                if ((ivl_t == '0) || !idx_ok)
                                begin
                                    pend_status_next = stb_pkg::ST_INVALID;
                                end
                                else
                                begin
                                    rem_we               = 1'b1;
                                    per_we               = 1'b1;
                                    running_next[tindex] = 1'b1;
                                    reload_next[tindex]  = periodic;
                                    pend_status_next     = stb_pkg::ST_OK;
                                end
                            end
                            stb_pkg::FUNC_STOP:
                            begin
                                if (!idx_ok)
                                begin
                                    pend_status_next = stb_pkg::ST_INVALID;
                                end
                                else
                                begin
                                    running_next[tindex] = 1'b0;
                                    pend_status_next     = stb_pkg::ST_OK;
                                end
                            end
                            stb_pkg::FUNC_TICK:
                            begin
                                // Start the walk at timer zero
                                idx_next   = '0;
                                el_next    = TIME_WIDTH'(elapsed);
                                state_next = S_FETCH;
                            end
                            default:
                            begin
                                pend_status_next = stb_pkg::ST_OK;
                            end
                        endcase
                    end
                end
            end
            S_FETCH:
            begin
                // Read address of the first timer goes out this cycle
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (advance)
                begin
                    if (cur_run)
                    begin
                        rem_we      = 1'b1;
                        rem_wr_addr = idx_reg;
                        rem_wr_data = unit_value;
                        if (unit_expire)
                        begin
                            running_next[idx_reg] = reload_reg[idx_reg];
                        end
                    end
                    if (need_emit)
                    begin
                        emit        = 1'b1;
                        emit_status = stb_pkg::ST_EXPIRY;
                        emit_idx    = 4'(idx_reg);
                    end
                    if (at_last)
                    begin
                        pend_status_next = stb_pkg::ST_OK;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        // Prefetch the next timer while this one writes back
                        idx_next = idx_reg + IDX_W'(1);
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    emit        = 1'b1;
                    emit_status = pend_status_reg;
                    emit_last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load on emit, drop valid once the transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        exp_idx_next   = exp_idx_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = emit_status;
            exp_idx_next   = emit_idx;
            last_next      = emit_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= 1'b0;
            running_reg   <= '0;
            reload_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            running_reg   <= running_next;
            reload_reg    <= reload_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        el_reg          <= el_next;
        pend_status_reg <= pend_status_next;
        status_reg      <= status_next;
        exp_idx_reg     <= exp_idx_next;
        last_reg        <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign expired_index = exp_idx_reg;
    assign last          = last_reg;

`ifndef NO_ASSERTIONS
    // An expiry event is never the final result of a tick
    a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == stb_pkg::ST_EXPIRY)) |-> !last_reg)
        else $error("expiry event marked last");

    // The walk only runs on an initialized bank
    a_walk_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FETCH) || (state_reg == S_EVAL)) |-> ready_reg)
        else $error("tick walk before init");

    // Finishing the last timer hands over to the done result
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && at_last) |=> (state_reg == S_DONE))
        else $error("walk did not end in done");

    // An expiry event names a timer inside the bank
    a_event_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == stb_pkg::ST_EXPIRY))
            |-> ({3'b000, exp_idx_reg} < NUM_T7))
        else $error("expiry index out of range");
`endif

endmodule

### hw/rtl/stb_ram.sv
// Simple dual-port memory: one write port, one read port with registered data.
// No dependencies; holds remaining times and periods of the timer bank.
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/stb_sub.sv
// Shared subtract and compare unit of the timer bank tick walk.
// No dependencies; instantiated once by soft_timer_bank.
module stb_sub #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] remaining,
    input  logic [WIDTH-1:0] elapsed,
    input  logic [WIDTH-1:0] period,
    input  logic             reload,
    output logic [WIDTH-1:0] next_value,
    output logic             expire
);

    logic [WIDTH:0]   diff_ext;
    logic [WIDTH-1:0] diff;

    assign diff_ext = {1'b0, remaining} - {1'b0, elapsed};
    assign diff     = diff_ext[WIDTH-1:0];

    // Expire when remaining <= elapsed: borrow out, or exact zero
    assign expire = diff_ext[WIDTH] || (diff == '0);

    always_comb
    begin
        if (!expire)
        begin
            next_value = diff;
        end
        else if (reload)
        begin
            next_value = period;
        end
        else
        begin
            next_value = '0;
        end
    end

endmodule
